// ===== hw/rtl/ctrm_pkg.sv =====
// Shared types and codes for the Cartesian-tree range-maximum engine.
// No dependencies; used by cartesian_tree_range_max_top and the testbench.
package ctrm_pkg;

   localparam int PosBits    = 10;
   localparam int ValueBits  = 32;
   localparam int FuncBits   = 2;
   localparam int StatusBits = 2;

   localparam logic [FuncBits-1:0] FuncAppend = 2'd0;
   localparam logic [FuncBits-1:0] FuncQuery  = 2'd1;
   localparam logic [FuncBits-1:0] FuncClear  = 2'd2;

   localparam logic [StatusBits-1:0] StatusOk    = 2'd0;
   localparam logic [StatusBits-1:0] StatusFull  = 2'd1;
   localparam logic [StatusBits-1:0] StatusRange = 2'd2;

   typedef struct packed {
      logic [FuncBits-1:0]         func;
      logic signed [ValueBits-1:0] value;
      logic [PosBits-1:0]          range_low;
      logic [PosBits-1:0]          range_high;
   } req_type;

   typedef struct packed {
      logic [StatusBits-1:0]       status;
      logic [PosBits-1:0]          max_position;
      logic signed [ValueBits-1:0] max_value;
   } rsp_type;

endpackage

// ===== hw/rtl/ctrm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; instanced by cartesian_tree_range_max_top.
module ctrm_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 1024,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cartesian_tree_range_max_top.sv =====
// Range-maximum engine over a max-heap Cartesian tree, built with a spine stack.
// Depends on ctrm_pkg (types, codes) and ctrm_ram (value, child and stack stores).
//
// One item at a time. An append checks the stack, then pops spine entries one
// by one (each pop is a stack read, a value read and one compare). When entries
// stay on the stack it ends with the stack read, value read and compare that end
// the pops, then the parent's right-link write. Pops amortize to about one per append.
// A query checks the range, reads the root, then visits the nodes of its walk, the
// root included, since each node is one registered read of the child and value stores.
// Clear, unused codes and a full store are answered straight from idle; a bad range
// after the range check. Every item then loads the result register once it is free.
// MAX_ELEMENTS ranges from 2 to 1024 (positions are 10 bits wide).
// No clearing pass: only entries below the element count are ever used.
module cartesian_tree_range_max_top #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ctrm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ctrm_pkg::rsp_type rsp_data
);

   localparam int AddrBits = $clog2(MAX_ELEMENTS);
   localparam int CntBits  = $clog2(MAX_ELEMENTS + 1);
   localparam int StepBits = CntBits + 1;
   localparam int CmpBits  = (ctrm_pkg::PosBits > StepBits) ? ctrm_pkg::PosBits : StepBits;
   localparam int VB       = ctrm_pkg::ValueBits;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_A_STK  = 9'b000000010,
      S_A_VAL  = 9'b000000100,
      S_A_CMP  = 9'b000001000,
      S_A_LINK = 9'b000010000,
      S_A_RLNK = 9'b000100000,
      S_Q_CHK  = 9'b001000000,
      S_Q_ROOT = 9'b010000000,
      S_Q_EVAL = 9'b100000000
   } state_type;

   // one extra state-like flag keeps the response slot separate from the walk
   state_type                   state_ff, state_in;
   logic                        resp_pend_ff, resp_pend_in;
   logic [CntBits-1:0]          count_ff, count_in;
   logic [CntBits-1:0]          depth_ff, depth_in;
   logic [AddrBits-1:0]         node_ff, node_in;
   logic [AddrBits-1:0]         lc_ff, lc_in;
   logic [AddrBits-1:0]         top_ff, top_in;
   logic                        has_top_ff, has_top_in;
   logic [StepBits-1:0]         steps_ff, steps_in;
   logic [ctrm_pkg::PosBits-1:0] lo_ff, lo_in, hi_ff, hi_in;
   ctrm_pkg::req_type           req_ff, req_in;
   ctrm_pkg::rsp_type           res_ff, res_in;
   ctrm_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        req_accept;
   logic                        slot_free;
   logic [CntBits-1:0]          depth_m1;
   logic [AddrBits-1:0]         pos;
   logic [AddrBits-1:0]         next_node;
   logic [AddrBits-1:0]         walk_addr;
   logic                        node_below, node_above;

   logic                        val_we, left_we, right_we, stk_we;
   logic [AddrBits-1:0]         val_waddr, left_waddr, right_waddr, stk_waddr;
   logic [VB-1:0]               val_wdata;
   logic [AddrBits-1:0]         left_wdata, right_wdata, stk_wdata;
   logic [AddrBits-1:0]         stk_raddr;
   logic [VB-1:0]               val_rdata;
   logic [AddrBits-1:0]         left_rdata, right_rdata, stk_rdata;

   ctrm_ram #(.WIDTH(VB), .DEPTH(MAX_ELEMENTS)) u_values (
      .clock(clock), .wr_en(val_we), .wr_addr(val_waddr), .wr_data(val_wdata),
      .rd_addr(walk_addr), .rd_data(val_rdata)
   );

   ctrm_ram #(.WIDTH(AddrBits), .DEPTH(MAX_ELEMENTS)) u_left (
      .clock(clock), .wr_en(left_we), .wr_addr(left_waddr), .wr_data(left_wdata),
      .rd_addr(walk_addr), .rd_data(left_rdata)
   );

   ctrm_ram #(.WIDTH(AddrBits), .DEPTH(MAX_ELEMENTS)) u_right (
      .clock(clock), .wr_en(right_we), .wr_addr(right_waddr), .wr_data(right_wdata),
      .rd_addr(walk_addr), .rd_data(right_rdata)
   );

   ctrm_ram #(.WIDTH(AddrBits), .DEPTH(MAX_ELEMENTS)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );

   assign req_stall  = (state_ff != S_IDLE) || resp_pend_ff;
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign depth_m1   = depth_ff - CntBits'(1);
   assign pos        = count_ff[AddrBits-1:0];
   assign node_below = CmpBits'(node_ff) < CmpBits'(lo_ff);
   assign node_above = CmpBits'(node_ff) > CmpBits'(hi_ff);
   assign next_node  = node_below ? right_rdata : left_rdata;
   // walk reads fetch the node the walk moves to next, else the stack output
   assign walk_addr  = (state_ff == S_Q_EVAL) ? next_node : stk_rdata;
   assign stk_raddr  = (state_ff == S_Q_CHK) ? '0 : depth_m1[AddrBits-1:0];

   // link writes: value, left link, own right link and stack push together, parent's right link next
   always_comb begin
      val_we      = (state_ff == S_A_LINK);
      val_waddr   = pos;
      val_wdata   = req_ff.value;
      left_we     = (state_ff == S_A_LINK);
      left_waddr  = pos;
      left_wdata  = lc_ff;
      right_we    = (state_ff == S_A_LINK) || (state_ff == S_A_RLNK);
      right_waddr = (state_ff == S_A_RLNK) ? top_ff : pos;
      right_wdata = pos;
      stk_we      = (state_ff == S_A_LINK);
      stk_waddr   = depth_ff[AddrBits-1:0];
      stk_wdata   = pos;
   end

   always_comb begin
      state_in     = state_ff;
      resp_pend_in = resp_pend_ff;
      count_in     = count_ff;
      depth_in     = depth_ff;
      node_in      = node_ff;
      lc_in        = lc_ff;
      top_in       = top_ff;
      has_top_in   = has_top_ff;
      steps_in     = steps_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      // move a finished result into the output register once it is free
      if (resp_pend_ff && slot_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
         resp_pend_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in = req_data;
               lc_in  = pos;
               if (req_data.range_low > req_data.range_high) begin
                  lo_in = req_data.range_high;
                  hi_in = req_data.range_low;
               end else begin
                  lo_in = req_data.range_low;
                  hi_in = req_data.range_high;
               end
               res_in.status       = ctrm_pkg::StatusOk;
               res_in.max_position = '0;
               res_in.max_value    = '0;
               unique case (req_data.func)
                  ctrm_pkg::FuncAppend: begin
                     if (count_ff >= CntBits'(MAX_ELEMENTS)) begin
                        res_in.status = ctrm_pkg::StatusFull;
                        resp_pend_in  = 1'b1;
                     end else begin
                        state_in = S_A_STK;
                     end
                  end
                  ctrm_pkg::FuncQuery: begin
                     state_in = S_Q_CHK;
                  end
                  ctrm_pkg::FuncClear: begin
                     count_in     = '0;
                     depth_in     = '0;
                     resp_pend_in = 1'b1;
                  end
                  default: begin
                     resp_pend_in = 1'b1;
                  end
               endcase
            end
         end

         S_A_STK: begin
            if (depth_ff == '0) begin
               has_top_in = 1'b0;
               state_in   = S_A_LINK;
            end else begin
               state_in = S_A_VAL;
            end
         end

         S_A_VAL: begin
            node_in  = stk_rdata;
            state_in = S_A_CMP;
         end

         S_A_CMP: begin
            // pop while the spine top is not above the new value
            if ($signed(val_rdata) <= req_ff.value) begin
               lc_in    = node_ff;
               depth_in = depth_m1;
               state_in = S_A_STK;
            end else begin
               top_in     = node_ff;
               has_top_in = 1'b1;
               state_in   = S_A_LINK;
            end
         end

         S_A_LINK: begin
            depth_in = depth_ff + CntBits'(1);
            res_in.status       = ctrm_pkg::StatusOk;
            res_in.max_position = ctrm_pkg::PosBits'(pos);
            res_in.max_value    = req_ff.value;
            if (has_top_ff) begin
               state_in = S_A_RLNK;
            end else begin
               count_in     = count_ff + CntBits'(1);
               resp_pend_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_A_RLNK: begin
            count_in     = count_ff + CntBits'(1);
            resp_pend_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_Q_CHK: begin
            if (count_ff == '0 || depth_ff == '0 ||
                CmpBits'(hi_ff) >= CmpBits'(count_ff)) begin
               res_in.status = ctrm_pkg::StatusRange;
               resp_pend_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_Q_ROOT;
            end
         end

         S_Q_ROOT: begin
            node_in  = stk_rdata;
            steps_in = '0;
            state_in = S_Q_EVAL;
         end

         S_Q_EVAL: begin
            if (steps_ff > StepBits'(count_ff) ||
                CntBits'(node_ff) >= count_ff) begin
               res_in.status = ctrm_pkg::StatusRange;
               resp_pend_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (!node_below && !node_above) begin
               res_in.status       = ctrm_pkg::StatusOk;
               res_in.max_position = ctrm_pkg::PosBits'(node_ff);
               res_in.max_value    = $signed(val_rdata);
               resp_pend_in        = 1'b1;
               state_in            = S_IDLE;
            end else begin
               node_in  = next_node;
               steps_in = steps_ff + StepBits'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         resp_pend_ff <= 1'b0;
         count_ff     <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resp_pend_ff <= resp_pend_in;
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      lc_ff      <= lc_in;
      top_ff     <= top_in;
      has_top_ff <= has_top_in;
      steps_ff   <= steps_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      req_ff     <= req_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for cartesian_tree_range_max_top: appends, range queries and clears
// checked against an in-bench Cartesian tree predictor. Depends on ctrm_pkg.
module tb;

   localparam int Capacity    = 1024;
   localparam int QuietLimit  = 20000;
   localparam int RandomItems = 1650;
   localparam int CalmFirst   = 450;
   localparam int CalmLast    = 750;

   localparam logic [ctrm_pkg::FuncBits-1:0] FuncUnused = 2'd3;

   class range_max_scoreboard;
      logic signed [ctrm_pkg::ValueBits-1:0] node_value [Capacity];
      logic [ctrm_pkg::PosBits-1:0]          left_link  [Capacity];
      logic [ctrm_pkg::PosBits-1:0]          right_link [Capacity];
      logic [ctrm_pkg::PosBits-1:0]          spine      [Capacity];
      int unsigned                           spine_depth;
      int unsigned                           node_count;
      ctrm_pkg::rsp_type                     pending_results [$];
      int                                    errors;
      int                                    appended, answered, full_hits, range_hits, clears;
      int unsigned                           deepest_spine;

      function new();
         spine_depth   = 0;
         node_count    = 0;
         errors        = 0;
         appended      = 0;
         answered      = 0;
         full_hits     = 0;
         range_hits    = 0;
         clears        = 0;
         deepest_spine = 0;
      endfunction

      function int unsigned stored();
         return node_count;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Advance the tree by one item and return the result it causes.
      function ctrm_pkg::rsp_type step_tree(ctrm_pkg::req_type r);
         ctrm_pkg::rsp_type            res;
         logic [ctrm_pkg::PosBits-1:0] pos, lc, lo, hi, node;
         int unsigned                  steps;
         bit                           found;
         res = '0;
         case (r.func)
            ctrm_pkg::FuncAppend: begin
               if (node_count >= Capacity) begin
                  res.status = ctrm_pkg::StatusFull;
               end else begin
                  pos = node_count[ctrm_pkg::PosBits-1:0];
                  node_value[pos] = r.value;
                  lc = pos;
                  // pop every spine entry not greater than the new value
                  while (spine_depth > 0 && node_value[spine[spine_depth-1]] <= r.value) begin
                     lc = spine[spine_depth-1];
                     spine_depth--;
                  end
                  left_link[pos]  = lc;
                  right_link[pos] = pos;
                  if (spine_depth > 0) right_link[spine[spine_depth-1]] = pos;
                  if (spine_depth < Capacity) begin
                     spine[spine_depth] = pos;
                     spine_depth++;
                  end
                  if (spine_depth > deepest_spine) deepest_spine = spine_depth;
                  node_count = node_count + 1;
                  res.status       = ctrm_pkg::StatusOk;
                  res.max_position = pos;
                  res.max_value    = r.value;
               end
            end
            ctrm_pkg::FuncQuery: begin
               lo = r.range_low;
               hi = r.range_high;
               if (lo > hi) begin
                  lo = r.range_high;
                  hi = r.range_low;
               end
               if (node_count == 0 || spine_depth == 0 || hi >= node_count) begin
                  res.status = ctrm_pkg::StatusRange;
               end else begin
                  node  = spine[0];
                  found = 1'b0;
                  for (steps = 0; steps <= node_count && node < node_count && !found;
                       steps++) begin
                     if (node < lo) begin
                        node = right_link[node];
                     end else if (node > hi) begin
                        node = left_link[node];
                     end else begin
                        found            = 1'b1;
                        res.status       = ctrm_pkg::StatusOk;
                        res.max_position = node;
                        res.max_value    = node_value[node];
                     end
                  end
                  if (!found) res.status = ctrm_pkg::StatusRange;
               end
            end
            ctrm_pkg::FuncClear: begin
               node_count  = 0;
               spine_depth = 0;
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_item(ctrm_pkg::req_type r);
         ctrm_pkg::rsp_type res;
         res = step_tree(r);
         pending_results.push_back(res);
         if (res.status == ctrm_pkg::StatusFull) full_hits++;
         else if (res.status == ctrm_pkg::StatusRange) range_hits++;
         else if (r.func == ctrm_pkg::FuncAppend) appended++;
         else if (r.func == ctrm_pkg::FuncQuery) answered++;
         else if (r.func == ctrm_pkg::FuncClear) clears++;
      endfunction

      function void report(string field, longint want, longint got);
         errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      endfunction

      function void check_result(ctrm_pkg::rsp_type got);
         ctrm_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %0d/%0d/%0d",
                     $time, got.status, got.max_position, got.max_value);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status) report("status", want.status, got.status);
         if (got.max_position !== want.max_position)
            report("max_position", want.max_position, got.max_position);
         if (got.max_value !== want.max_value)
            report("max_value", want.max_value, got.max_value);
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ctrm_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ctrm_pkg::rsp_type rsp_data;

   range_max_scoreboard sb;
   int                  items_sent  = 0;
   int                  quiet_count = 0;
   bit                  calm        = 1'b0;

   cartesian_tree_range_max_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 30);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else if (quiet_count >= QuietLimit) begin
         $display("%0t: timeout, no item moved for %0d cycles", $time, QuietLimit);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   function automatic ctrm_pkg::req_type random_fields();
      ctrm_pkg::req_type r;
      r.func       = ctrm_pkg::FuncBits'($urandom);
      r.value      = $urandom;
      r.range_low  = ctrm_pkg::PosBits'($urandom);
      r.range_high = ctrm_pkg::PosBits'($urandom);
      return r;
   endfunction

   task automatic drive_item(input ctrm_pkg::req_type item);
      while (!calm && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      // hold until the block takes the item
      do @(posedge clock); while (req_stall);
      sb.note_item(item);
      items_sent++;
      calm = (items_sent >= CalmFirst) && (items_sent < CalmLast);
   endtask

   task automatic append_value(input logic signed [ctrm_pkg::ValueBits-1:0] v);
      ctrm_pkg::req_type r;
      r       = random_fields();
      r.func  = ctrm_pkg::FuncAppend;
      r.value = v;
      drive_item(r);
   endtask

   task automatic query_range(input int unsigned lo, input int unsigned hi);
      ctrm_pkg::req_type r;
      r            = random_fields();
      r.func       = ctrm_pkg::FuncQuery;
      r.range_low  = lo[ctrm_pkg::PosBits-1:0];
      r.range_high = hi[ctrm_pkg::PosBits-1:0];
      drive_item(r);
   endtask

   task automatic control_item(input logic [ctrm_pkg::FuncBits-1:0] f);
      ctrm_pkg::req_type r;
      r      = random_fields();
      r.func = f;
      drive_item(r);
   endtask

   task automatic random_query();
      int unsigned count, lo, hi;
      count = sb.stored();
      if (count == 0 || $urandom_range(0, 9) == 0) begin
         query_range($urandom_range(0, Capacity - 1), $urandom_range(0, Capacity - 1));
      end else begin
         lo = $urandom_range(0, count - 1);
         if ($urandom_range(0, 9) < 3) hi = lo + $urandom_range(0, 3);
         else hi = $urandom_range(0, count - 1);
         if (hi >= count) hi = count - 1;
         if ($urandom_range(0, 1)) query_range(lo, hi);
         else query_range(hi, lo);
      end
   endtask

   function automatic logic signed [ctrm_pkg::ValueBits-1:0] pick_value(int mode, int idx);
      case (mode)
         0: return $urandom;
         1: return int'($urandom_range(0, 6)) - 3;
         2: return idx * 37 - 5000;
         3: return 5000 - idx * 37;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 0;
               3: return -1;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   task automatic run_session();
      int unsigned n;
      int          mode, i;
      n    = $urandom_range(1, 40);
      mode = $urandom_range(0, 4);
      for (i = 0; i < n; i++) begin
         append_value(pick_value(mode, i));
         if ($urandom_range(0, 99) < 40) random_query();
         if ($urandom_range(0, 99) < 5) control_item(FuncUnused);
      end
      random_query();
      random_query();
      if ($urandom_range(0, 9) < 7) control_item(ctrm_pkg::FuncClear);
   endtask

   initial begin
      bit filled;
      int i;
      sb     = new();
      filled = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, unused code, extreme and equal values, bound cases
      query_range(0, 0);
      control_item(FuncUnused);
      append_value(32'h7fff_ffff);
      append_value(32'h8000_0000);
      append_value(-1);
      append_value(-1);
      append_value(0);
      append_value(32'h7fff_ffff);
      query_range(0, 5);
      query_range(5, 0);
      query_range(1, 2);
      query_range(3, 3);
      query_range(2, 4);
      query_range(0, 6);
      query_range(Capacity - 1, 0);
      query_range(Capacity - 1, Capacity - 1);
      control_item(ctrm_pkg::FuncClear);
      query_range(0, 0);
      append_value(32'h8000_0000);
      query_range(0, 0);
      append_value(32'h8000_0000);
      query_range(1, 0);
      control_item(ctrm_pkg::FuncClear);

      while (items_sent < RandomItems) begin
         if (!filled && items_sent >= 250) begin
            // fill the store to the top, then push past it
            filled = 1'b1;
            control_item(ctrm_pkg::FuncClear);
            for (i = 0; i < Capacity + 3; i++) begin
               append_value(pick_value((i / 128) % 5, i));
               if (i % 16 == 15) random_query();
            end
            query_range(0, Capacity - 1);
            query_range(Capacity - 1, 0);
            query_range(Capacity - 1, Capacity - 1);
            control_item(ctrm_pkg::FuncClear);
         end else begin
            run_session();
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("run: %0d items, %0d appends, %0d answered queries, %0d clears",
               items_sent, sb.appended, sb.answered, sb.clears);
      $display("run: %0d full rejections, %0d range rejections, spine depth up to %0d",
               sb.full_hits, sb.range_hits, sb.deepest_spine);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
